// ===== sv/ohlcv_pkg.sv =====
// Shared types and constants for the OHLCV bar resampler.
// Used by ohlcv_win_calc and ohlcv_bar_resampler_core; no dependencies.
package ohlcv_pkg;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned VOL_IN_W  = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned LEN_W     = 52;
  localparam int unsigned CNT_W     = 6;

  localparam int unsigned PRICE_WIDTH_DEF      = 32;
  localparam int unsigned VOLUME_ACC_WIDTH_DEF = 48;

  localparam logic [LEN_W-1:0] NS_PER_MIN = 52'd60000000000;
  localparam logic [CFG_W-1:0] CFG_RESET  = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT_PRE_PASS,
    ST_EMIT_PRE_OPEN,
    ST_EMIT_IN,
    ST_CALC,
    ST_MERGE,
    ST_FLUSH
  } core_state_e;

  typedef enum logic [1:0] {
    WC_IDLE,
    WC_DIV,
    WC_BASE,
    WC_END
  } wc_state_e;

  typedef struct packed {
    logic start;
  } wc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wc_stat_t;

endpackage

// ===== sv/ohlcv_win_calc.sv =====
// Window end calculator: radix-2 remainder of the timestamp by the window
// length, then window start and exclusive end, all on one shared adder.
// Depends on ohlcv_pkg.
module ohlcv_win_calc
  import ohlcv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wc_ctrl_t          ctrl_i,
  input  logic [TS_W-1:0]   ts_i,
  input  logic [LEN_W-1:0]  len_i,
  output wc_stat_t          stat_o,
  output logic [TS_W:0]     wend_o
);

  wc_state_e         st_q, st_d;
  logic [TS_W:0]     acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TS_W:0]     shifted;
  logic [TS_W:0]     op_a, op_b, sum;
  logic              op_sub;

  assign shifted = {acc_q[TS_W-1:0], ts_i[cnt_q]};
  assign sum     = op_sub ? (op_a - op_b) : (op_a + op_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= WC_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    op_a   = shifted;
    op_b   = (TS_W+1)'(len_i);
    op_sub = 1'b1;
    stat_o = '{busy: (st_q != WC_IDLE), done: 1'b0};
    unique case (st_q)
      WC_IDLE: begin
        if (ctrl_i.start) begin
          acc_d = '0;
          cnt_d = '1;
          st_d  = WC_DIV;
        end
      end
      WC_DIV: begin
        acc_d = sum[TS_W] ? shifted : sum;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = WC_BASE;
        end
      end
      WC_BASE: begin
        op_a  = {1'b0, ts_i};
        op_b  = acc_q;
        acc_d = sum;
        st_d  = WC_END;
      end
      WC_END: begin
        op_a        = acc_q;
        op_sub      = 1'b0;
        acc_d       = sum;
        stat_o.done = 1'b1;
        st_d        = WC_IDLE;
      end
      default: st_d = WC_IDLE;
    endcase
  end

  assign wend_o = sum;

endmodule

// ===== sv/ohlcv_bar_resampler_core.sv =====
// OHLCV bar resampler top level: input capture, held bar, merge and output
// register under one sequencer. Depends on ohlcv_pkg and ohlcv_win_calc.
//
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: bar, tlast: end of data
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: coarse bar, tlast: last of item
// cfg      | in  | cfg_we_i                      | cfg_wdata_i: interval in minutes
//
// A bar that opens a window holds off the next accept for the 64-step radix-2
// remainder in ohlcv_win_calc, with the held bar sent out before it and a flush
// after it where needed. A merged or passed-through bar needs no remainder.
// Reset clears the held bar and loads an interval of one minute (pass-through).
// A result waits in the output register while the next bar is accepted; a
// stalled output holds the sequencer only when another result must be loaded.
module ohlcv_bar_resampler_core
  import ohlcv_pkg::*;
#(
  parameter int unsigned PRICE_WIDTH      = PRICE_WIDTH_DEF,
  parameter int unsigned VOLUME_ACC_WIDTH = VOLUME_ACC_WIDTH_DEF,
  localparam int unsigned IN_TDATA_W =
    ((TS_W + 4*PRICE_WIDTH + VOL_IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W =
    ((TS_W + 4*PRICE_WIDTH + VOLUME_ACC_WIDTH + 7) / 8) * 8
)
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // timestamp, open_price, high_price, low_price, close_price, trade_volume
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // bar_timestamp, bar_open, bar_high, bar_low, bar_close, bar_volume
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int unsigned PW = PRICE_WIDTH;
  localparam int unsigned VW = VOLUME_ACC_WIDTH;

  core_state_e          state_q, state_d;

  logic                 pass_q;
  logic [LEN_W-1:0]     len_q;

  logic [TS_W-1:0]      in_ts_q;
  logic [PW-1:0]        in_open_q, in_high_q, in_low_q, in_close_q;
  logic [VOL_IN_W-1:0]  in_vol_q;
  logic                 in_eod_q;

  logic                 held_valid_q;
  logic [TS_W-1:0]      held_ts_q;
  logic [PW-1:0]        held_open_q, held_high_q, held_low_q, held_close_q;
  logic [VW-1:0]        held_vol_q;
  logic [TS_W:0]        held_wend_q;

  logic                 out_valid_q;
  logic [TS_W-1:0]      out_ts_q;
  logic [PW-1:0]        out_open_q, out_high_q, out_low_q, out_close_q;
  logic [VW-1:0]        out_vol_q;
  logic                 out_last_q;

  wc_ctrl_t             calc_ctrl;
  wc_stat_t             calc_stat;
  logic [TS_W:0]        calc_wend;

  logic                 in_fire, out_free, joins;
  logic                 load_held_out, load_in_out, last_sel;
  logic                 do_open, do_merge, clr_held;
  logic [VW:0]          vol_sum;

  ohlcv_win_calc u_win_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (calc_ctrl),
    .ts_i   (in_ts_q),
    .len_i  (len_q),
    .stat_o (calc_stat),
    .wend_o (calc_wend)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign joins    = ({1'b0, in_ts_q} < held_wend_q);
  assign vol_sum  = {1'b0, held_vol_q} + (VW+1)'(in_vol_q);

  always_comb begin
    state_d         = state_q;
    s_axis_tready   = 1'b0;
    calc_ctrl.start = 1'b0;
    load_held_out   = 1'b0;
    load_in_out     = 1'b0;
    last_sel        = 1'b0;
    do_open         = 1'b0;
    do_merge        = 1'b0;
    clr_held        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (pass_q) begin
          state_d = held_valid_q ? ST_EMIT_PRE_PASS : ST_EMIT_IN;
        end else if (!held_valid_q) begin
          calc_ctrl.start = 1'b1;
          state_d         = ST_CALC;
        end else if (joins) begin
          state_d = ST_MERGE;
        end else begin
          state_d = ST_EMIT_PRE_OPEN;
        end
      end
      ST_EMIT_PRE_PASS: begin
        if (out_free) begin
          load_held_out = 1'b1;
          clr_held      = 1'b1;
          state_d       = ST_EMIT_IN;
        end
      end
      ST_EMIT_PRE_OPEN: begin
        if (out_free) begin
          load_held_out   = 1'b1;
          last_sel        = !in_eod_q;
          calc_ctrl.start = 1'b1;
          state_d         = ST_CALC;
        end
      end
      ST_EMIT_IN: begin
        if (out_free) begin
          load_in_out = 1'b1;
          last_sel    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (calc_stat.done) begin
          do_open = 1'b1;
          state_d = in_eod_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_MERGE: begin
        do_merge = 1'b1;
        state_d  = in_eod_q ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          load_held_out = 1'b1;
          last_sel      = 1'b1;
          clr_held      = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pass_q       <= 1'b1;
      len_q        <= NS_PER_MIN;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pass_q <= (cfg_wdata_i <= CFG_RESET);
        len_q  <= LEN_W'(cfg_wdata_i) * NS_PER_MIN;
      end
      if (do_open) begin
        held_valid_q <= 1'b1;
      end else if (clr_held) begin
        held_valid_q <= 1'b0;
      end
      if (load_held_out || load_in_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_ts_q    <= s_axis_tdata[TS_W-1:0];
      in_open_q  <= s_axis_tdata[TS_W +: PW];
      in_high_q  <= s_axis_tdata[TS_W+PW +: PW];
      in_low_q   <= s_axis_tdata[TS_W+2*PW +: PW];
      in_close_q <= s_axis_tdata[TS_W+3*PW +: PW];
      in_vol_q   <= s_axis_tdata[TS_W+4*PW +: VOL_IN_W];
      in_eod_q   <= s_axis_tlast;
    end
    if (do_open) begin
      held_ts_q    <= in_ts_q;
      held_open_q  <= in_open_q;
      held_high_q  <= in_high_q;
      held_low_q   <= in_low_q;
      held_close_q <= in_close_q;
      held_vol_q   <= VW'(in_vol_q);
      held_wend_q  <= calc_wend;
    end else if (do_merge) begin
      if ($signed(in_high_q) > $signed(held_high_q)) begin
        held_high_q <= in_high_q;
      end
      if ($signed(in_low_q) < $signed(held_low_q)) begin
        held_low_q <= in_low_q;
      end
      held_close_q <= in_close_q;
      held_vol_q   <= vol_sum[VW] ? '1 : vol_sum[VW-1:0];
    end
    if (load_held_out) begin
      out_ts_q    <= held_ts_q;
      out_open_q  <= held_open_q;
      out_high_q  <= held_high_q;
      out_low_q   <= held_low_q;
      out_close_q <= held_close_q;
      out_vol_q   <= held_vol_q;
      out_last_q  <= last_sel;
    end else if (load_in_out) begin
      out_ts_q    <= in_ts_q;
      out_open_q  <= in_open_q;
      out_high_q  <= in_high_q;
      out_low_q   <= in_low_q;
      out_close_q <= in_close_q;
      out_vol_q   <= VW'(in_vol_q);
      out_last_q  <= last_sel;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_vol_q, out_close_q, out_low_q, out_high_q,
                                       out_open_q, out_ts_q});

  a_calc_busy_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_stat.busy |-> (state_q == ST_CALC))
    else $error("window calculator busy outside the calc state");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!calc_stat.busy && (state_q == ST_IDLE)))
    else $error("input ready while an item is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_held_out || load_in_out) |-> (!out_valid_q || m_axis_tready))
    else $error("output word overwritten before it was taken");

  a_flush_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> held_valid_q)
    else $error("flush without a held bar");

endmodule
